/* src/tyuv_pkg.sv */
// Package for the tiled YUV 4:2:0 to RGB565 converter: types, constants, register map.
package tyuv_pkg;

   // Bounds of the tile counts and their defaults
   localparam int MAX_TILE_COLUMNS_DEF = 128;
   localparam int MAX_TILE_ROWS_DEF    = 128;

   // Widths
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 13;
   localparam int TILE_W    = 8;   // tile_columns / tile_rows registers
   localparam int EFF_W     = 9;   // effective count, holds up to 256
   localparam int CROP_W    = 13;
   localparam int POS_W     = 13;  // picture row / column
   localparam int POS1_W    = 14;  // column plus one, line stride
   localparam int IDX_W     = 24;
   localparam int ACC_W     = 20;  // signed conversion accumulator

   // Register map
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TILE_COLUMNS = 3'd0,
      CSR_TILE_ROWS    = 3'd1,
      CSR_CROP_TOP     = 3'd2,
      CSR_CROP_BOTTOM  = 3'd3,
      CSR_CROP_LEFT    = 3'd4,
      CSR_CROP_RIGHT   = 3'd5
   } csr_index_type;

   // Reset values of the registers
   localparam logic [TILE_W-1:0] TILE_COLUMNS_RST = 8'd1;
   localparam logic [TILE_W-1:0] TILE_ROWS_RST    = 8'd1;
   localparam logic [CROP_W-1:0] CROP_TOP_RST     = 13'd0;
   localparam logic [CROP_W-1:0] CROP_BOTTOM_RST  = 13'd4096;
   localparam logic [CROP_W-1:0] CROP_LEFT_RST    = 13'd0;
   localparam logic [CROP_W-1:0] CROP_RIGHT_RST   = 13'd4096;

   // Tile geometry
   localparam logic [3:0] LAST_PAIR = 4'd15;
   localparam logic [4:0] LAST_LINE = 5'd31;

   // BT.601 integer coefficients and offsets
   localparam logic signed [ACC_W-1:0] COEF_Y   = 20'sd298;
   localparam logic signed [ACC_W-1:0] COEF_RV  = 20'sd409;
   localparam logic signed [ACC_W-1:0] COEF_GU  = 20'sd100;
   localparam logic signed [ACC_W-1:0] COEF_GV  = 20'sd208;
   localparam logic signed [ACC_W-1:0] COEF_BU  = 20'sd517;
   localparam logic signed [ACC_W-1:0] Y_OFFSET = 20'sd16;
   localparam logic signed [ACC_W-1:0] C_OFFSET = 20'sd128;

   typedef struct packed {
      logic [7:0] luma_first;
      logic [7:0] luma_second;
      logic [7:0] chroma_u;
      logic [7:0] chroma_v;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0] pixel_index;
      logic [15:0]      rgb_first;
      logic [15:0]      rgb_second;
      logic             frame_end;
   } rsp_type;

endpackage

/* src/tyuv_convert.sv */
// One pixel of integer BT.601 YUV to RGB565, zeroed when outside the crop window.
module tyuv_convert (
   input  logic [7:0]  luma,
   input  logic [7:0]  chroma_u,
   input  logic [7:0]  chroma_v,
   input  logic        visible,
   output logic [15:0] rgb
);

   logic signed [tyuv_pkg::ACC_W-1:0] c_s, d_s, e_s, base_s;
   logic signed [tyuv_pkg::ACC_W-1:0] r_acc, g_acc, b_acc;
   logic [7:0] r_val, g_val, b_val;

   // Divide by 256 and clamp to 0..255; a negative sum clamps to zero.
   function automatic logic [7:0] clamp_div(input logic signed [tyuv_pkg::ACC_W-1:0] acc);
      logic [7:0] res;
      if (acc[tyuv_pkg::ACC_W-1]) begin
         res = 8'd0;
      end else if (|acc[tyuv_pkg::ACC_W-2:16]) begin
         res = 8'hff;
      end else begin
         res = acc[15:8];
      end
      return res;
   endfunction

   always_comb begin
      c_s    = $signed({12'd0, luma})     - tyuv_pkg::Y_OFFSET;
      d_s    = $signed({12'd0, chroma_u}) - tyuv_pkg::C_OFFSET;
      e_s    = $signed({12'd0, chroma_v}) - tyuv_pkg::C_OFFSET;
      base_s = c_s * tyuv_pkg::COEF_Y;
      r_acc  = base_s + e_s * tyuv_pkg::COEF_RV;
      g_acc  = base_s - d_s * tyuv_pkg::COEF_GU - e_s * tyuv_pkg::COEF_GV;
      b_acc  = base_s + d_s * tyuv_pkg::COEF_BU;
      r_val  = clamp_div(r_acc);
      g_val  = clamp_div(g_acc);
      b_val  = clamp_div(b_acc);
      rgb    = visible ? {r_val[7:3], g_val[7:2], b_val[7:3]} : 16'd0;
   end

endmodule

/* src/tiled_yuv420_to_rgb565_unit.sv */
// Top level of the tiled YUV 4:2:0 to RGB565 converter.
//
// Usage
//  - req_*: one transfer carries two adjacent luma samples and their shared
//    U/V pair, in 32x32 tile scan order (tile rows, tile columns, 32 lines,
//    16 pairs per line). The block tracks the position itself.
//  - rsp_*: one transfer per request: linear index of the even pixel, the two
//    RGB565 pixels (zero outside the crop window) and frame_end on the last
//    pair of the picture.
//  - csr_*: plain write port, one register per index; write only while idle.
//    Indexes beyond the register map are dropped.
// Timing
//  - Two-stage pipeline: position/crop stage, then conversion and index
//    multiply into the result register. An accepted request passes through
//    both in turn to rsp_*. One pair per cycle while the receiver keeps up.
//  - When the receiver stalls, the result register holds and req_ready falls
//    only once the position stage is also full; nothing is lost.
// Reset
//  - Synchronous reset empties both stages, returns the position counters to
//    the first pair of the picture and loads the register reset values.
module tiled_yuv420_to_rgb565_unit #(
   parameter int MAX_TILE_COLUMNS = tyuv_pkg::MAX_TILE_COLUMNS_DEF,
   parameter int MAX_TILE_ROWS    = tyuv_pkg::MAX_TILE_ROWS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  tyuv_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output tyuv_pkg::rsp_type               rsp_data,
   input  logic                            csr_we,
   input  logic [tyuv_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tyuv_pkg::CSR_DAT_W-1:0]  csr_wdata
);

   localparam int COL_W = (MAX_TILE_COLUMNS > 1) ? $clog2(MAX_TILE_COLUMNS) : 1;
   localparam int ROW_W = (MAX_TILE_ROWS > 1)    ? $clog2(MAX_TILE_ROWS)    : 1;
   localparam logic [tyuv_pkg::EFF_W-1:0] MAX_COLS = tyuv_pkg::EFF_W'(MAX_TILE_COLUMNS);
   localparam logic [tyuv_pkg::EFF_W-1:0] MAX_ROWS = tyuv_pkg::EFF_W'(MAX_TILE_ROWS);

   // Configuration registers
   logic [tyuv_pkg::TILE_W-1:0] tile_columns_ff, tile_rows_ff;
   logic [tyuv_pkg::CROP_W-1:0] crop_top_ff, crop_bottom_ff, crop_left_ff, crop_right_ff;

   // Position counters
   logic [ROW_W-1:0] row_count_ff, row_count_in;
   logic [COL_W-1:0] col_count_ff, col_count_in;
   logic [4:0]       line_ff, line_in;
   logic [3:0]       pair_ff, pair_in;

   // Position stage
   logic                          s1_valid_ff;
   tyuv_pkg::req_type             s1_req_ff;
   logic [tyuv_pkg::POS_W-1:0]    s1_row_ff, s1_col_ff;
   logic [tyuv_pkg::POS1_W-1:0]   s1_width_ff;
   logic                          s1_end_ff, s1_vis0_ff, s1_vis1_ff;

   // Result stage
   logic                          rsp_valid_ff;
   tyuv_pkg::rsp_type             rsp_ff, rsp_in;

   logic                          advance, req_take;
   logic [tyuv_pkg::EFF_W-1:0]    cols_eff, rows_eff;
   logic                          last_col, last_row;
   logic [tyuv_pkg::POS_W-1:0]    row_pos, col_pos;
   logic [tyuv_pkg::POS1_W-1:0]   col_next, width_pos;
   logic                          row_ok, vis0, vis1;
   logic [26:0]                   index_prod;
   logic [15:0]                   rgb0, rgb1;

   // Handshake: the result register advances when empty or taken; the
   // position stage takes a new pair whenever it can pass its own one on.
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = !s1_valid_ff || advance;
   assign req_take  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         tile_columns_ff <= tyuv_pkg::TILE_COLUMNS_RST;
         tile_rows_ff    <= tyuv_pkg::TILE_ROWS_RST;
         crop_top_ff     <= tyuv_pkg::CROP_TOP_RST;
         crop_bottom_ff  <= tyuv_pkg::CROP_BOTTOM_RST;
         crop_left_ff    <= tyuv_pkg::CROP_LEFT_RST;
         crop_right_ff   <= tyuv_pkg::CROP_RIGHT_RST;
      end else if (csr_we) begin
         case (csr_index)
            tyuv_pkg::CSR_TILE_COLUMNS: tile_columns_ff <= csr_wdata[tyuv_pkg::TILE_W-1:0];
            tyuv_pkg::CSR_TILE_ROWS:    tile_rows_ff    <= csr_wdata[tyuv_pkg::TILE_W-1:0];
            tyuv_pkg::CSR_CROP_TOP:     crop_top_ff     <= csr_wdata;
            tyuv_pkg::CSR_CROP_BOTTOM:  crop_bottom_ff  <= csr_wdata;
            tyuv_pkg::CSR_CROP_LEFT:    crop_left_ff    <= csr_wdata;
            tyuv_pkg::CSR_CROP_RIGHT:   crop_right_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Effective tile counts: zero acts as one, anything above the maximum as the maximum
   always_comb begin
      if (tile_columns_ff == '0) begin
         cols_eff = tyuv_pkg::EFF_W'(1);
      end else if (tyuv_pkg::EFF_W'(tile_columns_ff) > MAX_COLS) begin
         cols_eff = MAX_COLS;
      end else begin
         cols_eff = tyuv_pkg::EFF_W'(tile_columns_ff);
      end
      if (tile_rows_ff == '0) begin
         rows_eff = tyuv_pkg::EFF_W'(1);
      end else if (tyuv_pkg::EFF_W'(tile_rows_ff) > MAX_ROWS) begin
         rows_eff = MAX_ROWS;
      end else begin
         rows_eff = tyuv_pkg::EFF_W'(tile_rows_ff);
      end
   end

   // Position of the current pair and its crop test; a counter at or past
   // the last tile counts as last, so a shrunk count wraps on the next carry.
   always_comb begin
      last_col  = (tyuv_pkg::EFF_W'(col_count_ff) + tyuv_pkg::EFF_W'(1)) >= cols_eff;
      last_row  = (tyuv_pkg::EFF_W'(row_count_ff) + tyuv_pkg::EFF_W'(1)) >= rows_eff;
      row_pos   = tyuv_pkg::POS_W'({row_count_ff, line_ff});
      col_pos   = tyuv_pkg::POS_W'({col_count_ff, pair_ff, 1'b0});
      col_next  = tyuv_pkg::POS1_W'(col_pos) + tyuv_pkg::POS1_W'(1);
      width_pos = tyuv_pkg::POS1_W'({cols_eff, 5'd0});
      row_ok    = (row_pos >= crop_top_ff) && (row_pos < crop_bottom_ff);
      vis0      = row_ok && (col_pos >= crop_left_ff) && (col_pos < crop_right_ff);
      vis1      = row_ok && (col_next >= tyuv_pkg::POS1_W'(crop_left_ff))
                         && (col_next <  tyuv_pkg::POS1_W'(crop_right_ff));
   end

   // Step the scan position: pair, line, tile column, tile row
   always_comb begin
      pair_in      = pair_ff;
      line_in      = line_ff;
      col_count_in = col_count_ff;
      row_count_in = row_count_ff;
      if (pair_ff != tyuv_pkg::LAST_PAIR) begin
         pair_in = pair_ff + 4'd1;
      end else begin
         pair_in = '0;
         if (line_ff != tyuv_pkg::LAST_LINE) begin
            line_in = line_ff + 5'd1;
         end else begin
            line_in = '0;
            if (!last_col) begin
               col_count_in = col_count_ff + COL_W'(1);
            end else begin
               col_count_in = '0;
               row_count_in = last_row ? '0 : row_count_ff + ROW_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pair_ff      <= '0;
         line_ff      <= '0;
         col_count_ff <= '0;
         row_count_ff <= '0;
         s1_valid_ff  <= 1'b0;
      end else begin
         if (req_take) begin
            pair_ff      <= pair_in;
            line_ff      <= line_in;
            col_count_ff <= col_count_in;
            row_count_ff <= row_count_in;
         end
         if (req_ready) begin
            s1_valid_ff <= req_valid;
         end
      end
   end

   // Position stage payload: hold while stalled
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_req_ff   <= req_data;
         s1_row_ff   <= row_pos;
         s1_col_ff   <= col_pos;
         s1_width_ff <= width_pos;
         s1_vis0_ff  <= vis0;
         s1_vis1_ff  <= vis1;
         s1_end_ff   <= last_row && last_col && (line_ff == tyuv_pkg::LAST_LINE)
                        && (pair_ff == tyuv_pkg::LAST_PAIR);
      end
   end

   // Conversion stage
   tyuv_convert u_conv_first (
      .luma     (s1_req_ff.luma_first),
      .chroma_u (s1_req_ff.chroma_u),
      .chroma_v (s1_req_ff.chroma_v),
      .visible  (s1_vis0_ff),
      .rgb      (rgb0)
   );

   tyuv_convert u_conv_second (
      .luma     (s1_req_ff.luma_second),
      .chroma_u (s1_req_ff.chroma_u),
      .chroma_v (s1_req_ff.chroma_v),
      .visible  (s1_vis1_ff),
      .rgb      (rgb1)
   );

   // Linear index wraps modulo 2^24
   always_comb begin
      index_prod         = 27'(s1_row_ff) * 27'(s1_width_ff);
      rsp_in.pixel_index = index_prod[tyuv_pkg::IDX_W-1:0] + tyuv_pkg::IDX_W'(s1_col_ff);
      rsp_in.rgb_first   = rgb0;
      rsp_in.rgb_second  = rgb1;
      rsp_in.frame_end   = s1_end_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s1_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule
